/* rtl/assert_macros.svh */
// ============================================================================
// assert_macros.svh
// Assertion macros for the block that checks its own control logic.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define APSP_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define APSP_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/apsp_pkg.sv */
// ============================================================================
// apsp_pkg
// Widths, opcodes and shared types of the all-pairs shortest path solver.
// ============================================================================
package apsp_pkg;

    // Vertex count must stay a power of two: a cell address is {row, col}.
    localparam int MAX_VERTICES = 16;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int ADDR_W       = 2 * VTX_W;
    localparam int CELLS        = MAX_VERTICES * MAX_VERTICES;

    localparam int OP_W         = 2;
    localparam int WEIGHT_W     = 16;
    localparam int DIST_W       = 20;
    localparam int VCOUNT_W     = 5;

    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    // Command queue depth must be a power of two so the pointers wrap.
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [QCNT_W-1:0]   QUEUE_FULL   = QCNT_W'(QUEUE_DEPTH);
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(MAX_VERTICES);
    localparam logic [VCOUNT_W-1:0] VCOUNT_MAX   = VCOUNT_W'(MAX_VERTICES);
    localparam logic [VTX_W-1:0]    LAST_VTX     = VTX_W'(MAX_VERTICES - 1);

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_SOLVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]     opcode;
        logic [VTX_W-1:0]    row_vertex;
        logic [VTX_W-1:0]    col_vertex;
        logic [WEIGHT_W-1:0] edge_weight;
    } cmd_t;

    // Head of the command queue as seen by the engine.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_slot_t;

    // One cell of the solved distance matrix.
    typedef struct packed {
        logic [DIST_W-1:0] path_len;
        logic              reach;
        logic [VTX_W-1:0]  hop;
    } path_ent_t;

    localparam int PATH_W = $bits(path_ent_t);

endpackage

/* rtl/apsp_in_if.sv */
// ============================================================================
// apsp_in_if
// Command channel: valid/ready handshake with one command as payload.
// ============================================================================
interface apsp_in_if;

    logic                          valid;
    logic                          ready;
    logic [apsp_pkg::OP_W-1:0]     opcode;
    logic [apsp_pkg::VTX_W-1:0]    row_vertex;
    logic [apsp_pkg::VTX_W-1:0]    col_vertex;
    logic [apsp_pkg::WEIGHT_W-1:0] edge_weight;

    modport source (
        output valid, opcode, row_vertex, col_vertex, edge_weight,
        input  ready
    );

    modport sink (
        input  valid, opcode, row_vertex, col_vertex, edge_weight,
        output ready
    );

endinterface

/* rtl/apsp_out_if.sv */
// ============================================================================
// apsp_out_if
// Result channel: valid/ready handshake with one pair result as payload.
// ============================================================================
interface apsp_out_if;

    logic                        valid;
    logic                        ready;
    logic [apsp_pkg::DIST_W-1:0] path_length;
    logic [apsp_pkg::VTX_W-1:0]  next_vertex;
    logic                        reachable;

    modport source (
        output valid, path_length, next_vertex, reachable,
        input  ready
    );

    modport sink (
        input  valid, path_length, next_vertex, reachable,
        output ready
    );

endinterface

/* rtl/all_pairs_shortest_path.sv */
// ============================================================================
// all_pairs_shortest_path
// Floyd-Warshall shortest path solver over a 16-vertex weighted digraph.
// ============================================================================
// The block keeps a 16 x 16 weight matrix (no edge where the weight is 0) and
// answers three commands on the cmd channel: a write stores one weight, a
// solve builds the distance and first-hop tables for the first vertex_count
// vertices, and a read returns distance, next hop and a reachable flag for
// one pair on the rsp channel; unreachable or out-of-range pairs read as all
// zero. A front stage takes each transfer, drops the unused opcode and parks
// the command in a two-entry queue, so cmd keeps flowing, until the queue
// fills, while the engine works or while a result waits on rsp. A solve
// loads the tables for the n active vertices, then for every (intermediate,
// source) pair fetches the source-to-intermediate distance and relaxes the
// row when that distance is reachable, and ends with a closing step. The
// relaxation runs one cell per cycle, paced by the two read ports of the
// distance table. A read of a pair that no solve has written since reset
// returns undefined data. vertex_count is written over APB at byte address
// 0, is clamped to 1..16 when used and should only be changed while no
// command is in flight.
// ============================================================================
`include "assert_macros.svh"

module all_pairs_shortest_path (
    input  logic                               clk,
    input  logic                               rst_n,
    apsp_in_if.sink                            cmd,
    apsp_out_if.source                         rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [apsp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [apsp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [apsp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    logic [apsp_pkg::VCOUNT_W-1:0] vertex_count_reg;
    logic [apsp_pkg::VCOUNT_W-1:0] vc_minus1;
    logic [apsp_pkg::VTX_W-1:0]    n_last;
    logic                          cfg_write;
    apsp_pkg::cmd_slot_t           slot;
    logic                          pop;

    // The APB port has a single register; the top address bit selects it and
    // the low bits are the byte offset inside the word.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = paddr[apsp_pkg::APB_ADDR_W-1] ? '0 :
                       apsp_pkg::APB_DATA_W'(vertex_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= apsp_pkg::VCOUNT_RESET;
        end
        else if (cfg_write && !paddr[apsp_pkg::APB_ADDR_W-1])
        begin
            vertex_count_reg <= pwdata[apsp_pkg::VCOUNT_W-1:0];
        end
    end

    // Highest active vertex index: a count of zero behaves as one vertex and
    // counts above the matrix size saturate to its last vertex.
    always_comb
    begin
        vc_minus1 = vertex_count_reg - 1'b1;
        if (vertex_count_reg == '0)
        begin
            n_last = '0;
        end
        else if (vertex_count_reg > apsp_pkg::VCOUNT_MAX)
        begin
            n_last = apsp_pkg::LAST_VTX;
        end
        else
        begin
            n_last = vc_minus1[apsp_pkg::VTX_W-1:0];
        end
    end

    // Front end: takes every transfer and queues the commands that do work.
    apsp_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .slot  (slot),
        .pop   (pop)
    );

    // Back end: owns the edge and distance tables and the result register.
    apsp_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .slot   (slot),
        .pop    (pop),
        .n_last (n_last),
        .rsp    (rsp)
    );

    // The engine only takes commands that are actually queued.
    `APSP_ASSERT_NOW(a_pop_needs_slot, clk, rst_n, pop, slot.valid, "pop from an empty command queue")
    // A read is only started when the result register is free.
    `APSP_ASSERT_NOW(a_read_slot_free, clk, rst_n, pop && (slot.cmd.opcode == apsp_pkg::OP_READ), !rsp.valid, "read started over a pending result")
    // Every result comes from a read taken by the engine, via the read wait state.
    `APSP_ASSERT_NOW(a_rsp_from_read, clk, rst_n, $rose(rsp.valid), $past(pop && (slot.cmd.opcode == apsp_pkg::OP_READ), 2), "result without a matching read")
    // A solve keeps the engine busy, so no command follows it at once.
    `APSP_ASSERT_NEXT(a_solve_holds_engine, clk, rst_n, pop && (slot.cmd.opcode == apsp_pkg::OP_SOLVE), !pop, "command taken during a solve")

endmodule

/* rtl/apsp_ram.sv */
// ============================================================================
// apsp_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module apsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/apsp_front.sv */
// ============================================================================
// apsp_front
// Accepts commands, drops unused opcodes and queues the rest for the engine.
// ============================================================================
module apsp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    apsp_in_if.sink              cmd,
    output apsp_pkg::cmd_slot_t  slot,
    input  logic                 pop
);

    apsp_pkg::cmd_t                    q_reg [apsp_pkg::QUEUE_DEPTH];
    logic [apsp_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [apsp_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [apsp_pkg::QCNT_W-1:0]       count_reg;
    logic [apsp_pkg::QCNT_W-1:0]       count_next;
    logic                              keep;
    logic                              push;
    logic                              do_pop;
    apsp_pkg::cmd_t                    cmd_in;

    assign cmd.ready = (count_reg != apsp_pkg::QUEUE_FULL);

    always_comb
    begin
        keep = (cmd.opcode == apsp_pkg::OP_WRITE) || (cmd.opcode == apsp_pkg::OP_SOLVE) ||
               (cmd.opcode == apsp_pkg::OP_READ);
        push = cmd.valid && cmd.ready && keep;
        do_pop = pop && (count_reg != '0);
        cmd_in.opcode      = cmd.opcode;
        cmd_in.row_vertex  = cmd.row_vertex;
        cmd_in.col_vertex  = cmd.col_vertex;
        cmd_in.edge_weight = cmd.edge_weight;
    end

    always_comb
    begin
        case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign slot.valid = (count_reg != '0);
    assign slot.cmd   = q_reg[rd_ptr_reg];

endmodule

/* rtl/apsp_engine.sv */
// ============================================================================
// apsp_engine
// Executes queued commands: edge writes, pair reads and the full solve.
// ============================================================================
module apsp_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  apsp_pkg::cmd_slot_t         slot,
    output logic                        pop,
    input  logic [apsp_pkg::VTX_W-1:0]  n_last,
    apsp_out_if.source                  rsp
);

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_RD_WAIT   = 8'b0000_0010,
        ST_INIT      = 8'b0000_0100,
        ST_INIT_END  = 8'b0000_1000,
        ST_SM_REQ    = 8'b0001_0000,
        ST_SM_WAIT   = 8'b0010_0000,
        ST_SWEEP     = 8'b0100_0000,
        ST_SOLVE_END = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t adv_state;

    logic [apsp_pkg::VTX_W-1:0]    m_reg, m_next, adv_m;
    logic [apsp_pkg::VTX_W-1:0]    s_reg, s_next, adv_s;
    logic [apsp_pkg::VTX_W-1:0]    e_reg, e_next;
    logic                          last_m, last_s, last_e;

    logic [apsp_pkg::CELLS-1:0]    edge_valid_reg;
    logic                          edge_vld_q_reg;
    logic                          edge_we;
    logic [apsp_pkg::WEIGHT_W-1:0] edge_q;

    logic                          init_v_reg;
    logic [apsp_pkg::ADDR_W-1:0]   init_addr_reg;
    apsp_pkg::path_ent_t           init_ent;

    logic                          relax_v_reg;
    logic [apsp_pkg::ADDR_W-1:0]   relax_addr_reg;
    logic [apsp_pkg::DIST_W-1:0]   sm_dist_reg;
    logic [apsp_pkg::VTX_W-1:0]    sm_hop_reg;
    logic [apsp_pkg::DIST_W:0]     via;
    logic                          relax_we;
    apsp_pkg::path_ent_t           relax_ent;

    logic [apsp_pkg::ADDR_W-1:0]   raddr_a;
    logic [apsp_pkg::ADDR_W-1:0]   raddr_b;
    logic [apsp_pkg::PATH_W-1:0]   rdata_a;
    logic [apsp_pkg::PATH_W-1:0]   rdata_b;
    apsp_pkg::path_ent_t           qa, qb;
    logic                          path_we;
    logic [apsp_pkg::ADDR_W-1:0]   path_waddr;
    apsp_pkg::path_ent_t           path_wdata;

    logic                          rd_range_reg;
    logic                          out_valid_reg;
    apsp_pkg::path_ent_t           out_ent_reg;

    assign last_m = (m_reg == n_last);
    assign last_s = (s_reg == n_last);
    assign last_e = (e_reg == n_last);

    // Step to the next (intermediate, source) pair of the relaxation.
    always_comb
    begin
        adv_state = ST_SM_REQ;
        adv_m     = m_reg;
        adv_s     = s_reg + 1'b1;
        if (last_s)
        begin
            adv_s = '0;
            if (last_m)
            begin
                adv_state = ST_SOLVE_END;
            end
            else
            begin
                adv_m = m_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        s_next     = s_reg;
        e_next     = e_reg;
        pop        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (slot.valid)
                begin
                    case (slot.cmd.opcode)
                        apsp_pkg::OP_SOLVE:
                        begin
                            pop        = 1'b1;
                            state_next = ST_INIT;
                            s_next     = '0;
                            e_next     = '0;
                        end
                        apsp_pkg::OP_READ:
                        begin
                            if (!out_valid_reg)
                            begin
                                pop        = 1'b1;
                                state_next = ST_RD_WAIT;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                state_next = ST_IDLE;
            end
            ST_INIT:
            begin
                if (last_e)
                begin
                    e_next = '0;
                    if (last_s)
                    begin
                        state_next = ST_INIT_END;
                    end
                    else
                    begin
                        s_next = s_reg + 1'b1;
                    end
                end
                else
                begin
                    e_next = e_reg + 1'b1;
                end
            end
            ST_INIT_END:
            begin
                state_next = ST_SM_REQ;
                m_next     = '0;
                s_next     = '0;
            end
            ST_SM_REQ:
            begin
                state_next = ST_SM_WAIT;
            end
            ST_SM_WAIT:
            begin
                if (qa.reach)
                begin
                    state_next = ST_SWEEP;
                    e_next     = '0;
                end
                else
                begin
                    state_next = adv_state;
                    m_next     = adv_m;
                    s_next     = adv_s;
                end
            end
            ST_SWEEP:
            begin
                if (last_e)
                begin
                    state_next = adv_state;
                    m_next     = adv_m;
                    s_next     = adv_s;
                end
                else
                begin
                    e_next = e_reg + 1'b1;
                end
            end
            ST_SOLVE_END:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Edge weights; cells never written read as no edge through the valid bits.
    assign edge_we = pop && (state_reg == ST_IDLE) && (slot.cmd.opcode == apsp_pkg::OP_WRITE);

    apsp_ram #(
        .WIDTH (apsp_pkg::WEIGHT_W),
        .DEPTH (apsp_pkg::CELLS)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr ({slot.cmd.row_vertex, slot.cmd.col_vertex}),
        .wdata (slot.cmd.edge_weight),
        .raddr ({s_reg, e_reg}),
        .rdata (edge_q)
    );

    always_comb
    begin
        init_ent = '0;
        if (init_addr_reg[apsp_pkg::ADDR_W-1:apsp_pkg::VTX_W] ==
            init_addr_reg[apsp_pkg::VTX_W-1:0])
        begin
            init_ent.reach = 1'b1;
        end
        else if (edge_vld_q_reg && (edge_q != '0))
        begin
            init_ent.path_len = apsp_pkg::DIST_W'(edge_q);
            init_ent.reach    = 1'b1;
            init_ent.hop      = init_addr_reg[apsp_pkg::VTX_W-1:0];
        end
    end

    // Port A serves the source-to-intermediate cell, the intermediate row
    // and pair reads; port B serves the row being relaxed.
    always_comb
    begin
        case (state_reg)
            ST_SM_REQ: raddr_a = {s_reg, m_reg};
            ST_SWEEP:  raddr_a = {m_reg, e_reg};
            default:   raddr_a = {slot.cmd.row_vertex, slot.cmd.col_vertex};
        endcase
        raddr_b = {s_reg, e_reg};
    end

    assign qa = apsp_pkg::path_ent_t'(rdata_a);
    assign qb = apsp_pkg::path_ent_t'(rdata_b);

    // Sums stay within the distance width for the supported vertex count.
    always_comb
    begin
        via                = {1'b0, sm_dist_reg} + {1'b0, qa.path_len};
        relax_we           = relax_v_reg && qa.reach &&
                             (!qb.reach || (via < {1'b0, qb.path_len}));
        relax_ent.path_len = via[apsp_pkg::DIST_W-1:0];
        relax_ent.reach    = 1'b1;
        relax_ent.hop      = sm_hop_reg;
    end

    assign path_we    = init_v_reg || relax_we;
    assign path_waddr = init_v_reg ? init_addr_reg : relax_addr_reg;
    assign path_wdata = init_v_reg ? init_ent : relax_ent;

    apsp_ram #(
        .WIDTH (apsp_pkg::PATH_W),
        .DEPTH (apsp_pkg::CELLS)
    ) u_path_ram_a (
        .clk   (clk),
        .we    (path_we),
        .waddr (path_waddr),
        .wdata (path_wdata),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    apsp_ram #(
        .WIDTH (apsp_pkg::PATH_W),
        .DEPTH (apsp_pkg::CELLS)
    ) u_path_ram_b (
        .clk   (clk),
        .we    (path_we),
        .waddr (path_waddr),
        .wdata (path_wdata),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            m_reg          <= '0;
            s_reg          <= '0;
            e_reg          <= '0;
            edge_valid_reg <= '0;
            init_v_reg     <= 1'b0;
            relax_v_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_reg       <= m_next;
            s_reg       <= s_next;
            e_reg       <= e_next;
            init_v_reg  <= (state_reg == ST_INIT);
            relax_v_reg <= (state_reg == ST_SWEEP);
            if (edge_we)
            begin
                edge_valid_reg[{slot.cmd.row_vertex, slot.cmd.col_vertex}] <= 1'b1;
            end
            if (state_reg == ST_RD_WAIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        edge_vld_q_reg <= edge_valid_reg[{s_reg, e_reg}];
        init_addr_reg  <= {s_reg, e_reg};
        relax_addr_reg <= {s_reg, e_reg};
        if (state_reg == ST_SM_WAIT)
        begin
            sm_dist_reg <= qa.path_len;
            sm_hop_reg  <= qa.hop;
        end
        if (pop)
        begin
            rd_range_reg <= (slot.cmd.row_vertex <= n_last) && (slot.cmd.col_vertex <= n_last);
        end
        if (state_reg == ST_RD_WAIT)
        begin
            out_ent_reg <= (rd_range_reg && qa.reach) ? qa : '0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.path_length = out_ent_reg.path_len;
    assign rsp.next_vertex = out_ent_reg.hop;
    assign rsp.reachable   = out_ent_reg.reach;

endmodule

/* tb/tb.sv */
// ============================================================================
// tb
// Self-checking bench for the all-pairs shortest path solver.
// ============================================================================
// Commands go into the cmd channel from a queue that the stimulus process
// fills. Each accepted write or solve updates an in-bench model of the edge
// matrix and of the solved distance, reach and first-hop tables. Each read
// leaves one predicted pair answer behind. The rsp monitor compares every
// result transfer, field by field, with the oldest predicted answer.
// vertex_count goes through several settings over APB, always while the
// solver is idle. The settings include zero, the maximum and a value above it.
// ============================================================================
module tb;

    localparam int CLK_PERIOD = 20;

    // The spare opcode is dropped by the block and never answered.
    localparam logic [apsp_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // Register map: vertex_count is register 0.
    localparam int REG_VERTEX_COUNT = 0;
    localparam logic [apsp_pkg::APB_ADDR_W-1:0] ADDR_VERTEX_COUNT =
        apsp_pkg::APB_ADDR_W'(4 * REG_VERTEX_COUNT);

    // A full 16-vertex solve fits within the settle time below. After the last
    // result of a phase, the bench waits that long before it touches the
    // register, because a solve can still be in progress.
    localparam int SOLVE_SETTLE = 5000;

    // The receiver stops once, for a long stretch, right after the first
    // result, while the directed reads are still being offered back to back.
    localparam int HOLD_AFTER_RESULTS = 1;
    localparam int HOLD_CYCLES        = 300;

    // The worst case is every item a full solve plus gaps. Settling and
    // the long hold add to that. The limit below covers that sum several
    // times over.
    localparam longint LIMIT_CYCLES = 2500000;

    typedef struct packed {
        logic [apsp_pkg::DIST_W-1:0] path_length;
        logic [apsp_pkg::VTX_W-1:0]  next_vertex;
        logic                        reachable;
    } pair_answer_t;

    logic                            clk;
    logic                            rst_n;
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [apsp_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [apsp_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [apsp_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    apsp_in_if  cmd_ch ();
    apsp_out_if rsp_ch ();

    all_pairs_shortest_path dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------------
    // Model state. The bench keeps its own copy of the register and of every
    // table that the solver holds.
    // ------------------------------------------------------------------------
    logic [apsp_pkg::VCOUNT_W-1:0] vcount_reg;
    logic [apsp_pkg::WEIGHT_W-1:0] edge_weights
        [apsp_pkg::MAX_VERTICES][apsp_pkg::MAX_VERTICES];
    logic [apsp_pkg::DIST_W:0]     solved_dist
        [apsp_pkg::MAX_VERTICES][apsp_pkg::MAX_VERTICES];
    logic                          solved_reach
        [apsp_pkg::MAX_VERTICES][apsp_pkg::MAX_VERTICES];
    logic [apsp_pkg::VTX_W-1:0]    solved_hop
        [apsp_pkg::MAX_VERTICES][apsp_pkg::MAX_VERTICES];

    pair_answer_t   pending_answers[$];
    apsp_pkg::cmd_t pending_cmds[$];

    int  mismatch_count = 0;
    int  results_checked = 0;
    int  writes_seen = 0;
    int  solves_seen = 0;
    int  reads_seen = 0;
    int  dropped_seen = 0;
    int  settings_used = 0;
    bit  steady_traffic = 1'b0;

    // A count of zero behaves as one; counts past the table size saturate.
    function automatic int active_vertices(input logic [apsp_pkg::VCOUNT_W-1:0] count);
        if (count == '0)
            return 1;
        if (count > apsp_pkg::VCOUNT_MAX)
            return apsp_pkg::MAX_VERTICES;
        return int'(count);
    endfunction

    // Floyd-Warshall as the solver runs it. The loader sets the diagonal to
    // zero, sets each stored edge to its weight and marks all other pairs
    // unreachable. Diagonal weights are ignored. Relaxation runs through
    // intermediates 0..n-1 in order. A detour replaces the current path only
    // when it is strictly shorter, and it takes the first hop of the path to
    // the intermediate.
    task automatic solve_tables();
        int                        n;
        logic [apsp_pkg::DIST_W:0] via;
        n = active_vertices(vcount_reg);
        for (int s = 0; s < n; s++)
        begin
            for (int e = 0; e < n; e++)
            begin
                if (s == e)
                begin
                    solved_dist[s][e]  = '0;
                    solved_reach[s][e] = 1'b1;
                    solved_hop[s][e]   = '0;
                end
                else if (edge_weights[s][e] != '0)
                begin
                    solved_dist[s][e]  = (apsp_pkg::DIST_W+1)'(edge_weights[s][e]);
                    solved_reach[s][e] = 1'b1;
                    solved_hop[s][e]   = apsp_pkg::VTX_W'(e);
                end
                else
                begin
                    solved_dist[s][e]  = '0;
                    solved_reach[s][e] = 1'b0;
                    solved_hop[s][e]   = '0;
                end
            end
        end
        for (int m = 0; m < n; m++)
        begin
            for (int s = 0; s < n; s++)
            begin
                if (!solved_reach[s][m])
                    continue;
                for (int e = 0; e < n; e++)
                begin
                    if (!solved_reach[m][e])
                        continue;
                    via = solved_dist[s][m] + solved_dist[m][e];
                    if (!solved_reach[s][e] || via < solved_dist[s][e])
                    begin
                        solved_dist[s][e]  = via;
                        solved_reach[s][e] = 1'b1;
                        solved_hop[s][e]   = solved_hop[s][m];
                    end
                end
            end
        end
    endtask

    // Updates the model for one accepted command. A read queues its answer.
    task automatic apply_command(input apsp_pkg::cmd_t c);
        pair_answer_t ans;
        int           n;
        case (c.opcode)
            apsp_pkg::OP_WRITE:
            begin
                edge_weights[c.row_vertex][c.col_vertex] = c.edge_weight;
                writes_seen++;
            end
            apsp_pkg::OP_SOLVE:
            begin
                solve_tables();
                solves_seen++;
            end
            apsp_pkg::OP_READ:
            begin
                n   = active_vertices(vcount_reg);
                ans = '0;
                if (int'(c.row_vertex) < n && int'(c.col_vertex) < n
                    && solved_reach[c.row_vertex][c.col_vertex])
                begin
                    // The sum can exceed 20 bits only with more than 16 vertices.
                    ans.path_length =
                        (solved_dist[c.row_vertex][c.col_vertex] >
                         (apsp_pkg::DIST_W+1)'('hFFFFF))
                        ? apsp_pkg::DIST_W'('hFFFFF)
                        : solved_dist[c.row_vertex][c.col_vertex][apsp_pkg::DIST_W-1:0];
                    ans.next_vertex = solved_hop[c.row_vertex][c.col_vertex];
                    ans.reachable   = 1'b1;
                end
                pending_answers.push_back(ans);
                reads_seen++;
            end
            default:
                dropped_seen++;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Clock, and the overall time limit.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Command driver. It pops the next command when the channel is free. The
    // idle gap that it draws for each item is spent after that item's
    // transfer. The model is updated at the edge where the transfer happens.
    // ------------------------------------------------------------------------
    apsp_pkg::cmd_t driven_cmd;
    int             send_wait;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid       <= 1'b0;
            cmd_ch.opcode      <= apsp_pkg::OP_WRITE;
            cmd_ch.row_vertex  <= '0;
            cmd_ch.col_vertex  <= '0;
            cmd_ch.edge_weight <= '0;
            send_wait = 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                apply_command(driven_cmd);
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    cmd_ch.valid <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    driven_cmd = pending_cmds.pop_front();
                    cmd_ch.opcode      <= driven_cmd.opcode;
                    cmd_ch.row_vertex  <= driven_cmd.row_vertex;
                    cmd_ch.col_vertex  <= driven_cmd.col_vertex;
                    cmd_ch.edge_weight <= driven_cmd.edge_weight;
                    cmd_ch.valid       <= 1'b1;
                    send_wait = steady_traffic ? 0 : $urandom_range(0, 9);
                end
                else
                begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. It checks each transfer against the oldest predicted
    // answer and then draws a stall before taking the next one. After
    // HOLD_AFTER_RESULTS results it holds ready low for a long stretch. The
    // solver then fills up and must push back on cmd.
    // ------------------------------------------------------------------------
    int  recv_wait;
    bit  long_hold_done;
    pair_answer_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            recv_wait = 0;
            long_hold_done = 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    $error("result transfer with no read outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (rsp_ch.path_length !== want.path_length)
                    begin
                        $error("path_length: expected %0d, got %0d",
                               want.path_length, rsp_ch.path_length);
                        mismatch_count++;
                    end
                    if (rsp_ch.next_vertex !== want.next_vertex)
                    begin
                        $error("next_vertex: expected %0d, got %0d",
                               want.next_vertex, rsp_ch.next_vertex);
                        mismatch_count++;
                    end
                    if (rsp_ch.reachable !== want.reachable)
                    begin
                        $error("reachable: expected %0d, got %0d",
                               want.reachable, rsp_ch.reachable);
                        mismatch_count++;
                    end
                end
                results_checked++;
                recv_wait = steady_traffic ? 0 : $urandom_range(0, 9);
                if (!long_hold_done && results_checked >= HOLD_AFTER_RESULTS)
                begin
                    recv_wait = HOLD_CYCLES;
                    long_hold_done = 1'b1;
                end
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic void push_cmd(input logic [apsp_pkg::OP_W-1:0] op, input int row,
                                     input int col, input int weight);
        apsp_pkg::cmd_t c;
        c.opcode      = op;
        c.row_vertex  = apsp_pkg::VTX_W'(row);
        c.col_vertex  = apsp_pkg::VTX_W'(col);
        c.edge_weight = apsp_pkg::WEIGHT_W'(weight);
        pending_cmds.push_back(c);
    endfunction

    // Mostly short edges, so that detours through intermediates often win.
    // Some draws give no edge, the largest weight or any weight.
    function automatic int draw_weight();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 65535;
            2:       return $urandom_range(1, 65535);
            default: return $urandom_range(1, 30);
        endcase
    endfunction

    // The directed solve covers every cell, so each later read is a read of
    // solved data. When fewer than 16 vertices are in use, some reads aim
    // past the active range on purpose.
    function automatic void push_read(input int n);
        int row;
        int col;
        row = $urandom_range(0, n - 1);
        col = $urandom_range(0, n - 1);
        if (n < apsp_pkg::MAX_VERTICES && $urandom_range(0, 4) == 0)
        begin
            if ($urandom_range(0, 1) == 0)
                row = $urandom_range(n, apsp_pkg::MAX_VERTICES - 1);
            else
                col = $urandom_range(n, apsp_pkg::MAX_VERTICES - 1);
        end
        push_cmd(apsp_pkg::OP_READ, row, col, $urandom_range(0, 65535));
    endfunction

    // Most traffic comes as edge writes, then a solve, then reads of the
    // fresh tables, all with random content. Now and then a write lands
    // outside the active vertices or the spare opcode is sent. Dropped
    // commands do not count toward the budget.
    task automatic queue_random_items(input int budget, input int n);
        int made;
        int burst;
        made = 0;
        while (made < budget)
        begin
            burst = $urandom_range(1, 5);
            for (int k = 0; k < burst; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_cmd(apsp_pkg::OP_WRITE,
                             $urandom_range(0, apsp_pkg::MAX_VERTICES - 1),
                             $urandom_range(0, apsp_pkg::MAX_VERTICES - 1), draw_weight());
                else
                    push_cmd(apsp_pkg::OP_WRITE, $urandom_range(0, n - 1),
                             $urandom_range(0, n - 1), draw_weight());
            end
            push_cmd(apsp_pkg::OP_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 65535));
            made += burst + 1;
            burst = $urandom_range(2, 6);
            for (int k = 0; k < burst; k++)
                push_read(n);
            made += burst;
            if ($urandom_range(0, 7) == 0)
                push_cmd(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                         $urandom_range(0, 65535));
        end
    endtask

    // One APB write: a setup cycle, then an access cycle. pready is always
    // high, so the register takes the value at the end of the access cycle.
    task automatic write_register(input logic [apsp_pkg::APB_ADDR_W-1:0] addr,
                                  input logic [apsp_pkg::APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_VERTEX_COUNT)
            vcount_reg = data[apsp_pkg::VCOUNT_W-1:0];
        settings_used++;
    endtask

    // Waits until every queued command has been sent and every answer has
    // been seen. Then it allows time for a solve that may still be running.
    task automatic drain_and_settle();
        while (pending_cmds.size() != 0 || cmd_ch.valid || pending_answers.size() != 0)
            @(negedge clk);
        repeat (SOLVE_SETTLE) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    logic [apsp_pkg::VCOUNT_W-1:0] phase_counts [7] =
        '{5'd3, 5'd0, 5'd5, 5'd31, 5'd2, 5'd16, 5'd4};
    int                            phase_items  [7] = '{16, 6, 20, 12, 12, 10, 16};

    initial
    begin
        cmd_ch.valid       = 1'b0;
        cmd_ch.opcode      = apsp_pkg::OP_WRITE;
        cmd_ch.row_vertex  = '0;
        cmd_ch.col_vertex  = '0;
        cmd_ch.edge_weight = '0;
        rsp_ch.ready       = 1'b0;
        rst_n              = 1'b0;

        vcount_reg = apsp_pkg::VCOUNT_RESET;
        for (int r = 0; r < apsp_pkg::MAX_VERTICES; r++)
        begin
            for (int c = 0; c < apsp_pkg::MAX_VERTICES; c++)
            begin
                edge_weights[r][c] = '0;
                solved_dist[r][c]  = '0;
                solved_reach[r][c] = 1'b0;
                solved_hop[r][c]   = '0;
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, with all 16 vertices as after reset. It uses the
        // heaviest edges and the outermost vertices. A short detour through one
        // intermediate beats a heavy direct edge. In a tie the direct edge stays.
        // A diagonal weight must be ignored. The spare opcode must produce no
        // result. Some pairs stay unreachable.
        steady_traffic = 1'b1;
        push_cmd(apsp_pkg::OP_WRITE, 0, 1, 65535);
        push_cmd(apsp_pkg::OP_WRITE, 1, 15, 65535);
        push_cmd(apsp_pkg::OP_WRITE, 15, 0, 1);
        push_cmd(apsp_pkg::OP_WRITE, 0, 15, 0);
        push_cmd(apsp_pkg::OP_WRITE, 5, 5, 7);
        push_cmd(apsp_pkg::OP_WRITE, 0, 2, 3);
        push_cmd(apsp_pkg::OP_WRITE, 2, 1, 4);
        push_cmd(apsp_pkg::OP_WRITE, 3, 4, 10);
        push_cmd(apsp_pkg::OP_WRITE, 3, 5, 4);
        push_cmd(apsp_pkg::OP_WRITE, 5, 4, 6);
        push_cmd(OP_UNUSED, 15, 15, 65535);
        push_cmd(apsp_pkg::OP_SOLVE, 0, 0, 0);
        push_cmd(apsp_pkg::OP_READ, 0, 1, 0);
        push_cmd(apsp_pkg::OP_READ, 0, 15, 0);
        push_cmd(apsp_pkg::OP_READ, 15, 0, 65535);
        push_cmd(apsp_pkg::OP_READ, 15, 2, 0);
        push_cmd(apsp_pkg::OP_READ, 5, 5, 0);
        push_cmd(apsp_pkg::OP_READ, 3, 4, 0);
        push_cmd(apsp_pkg::OP_READ, 4, 3, 0);
        push_cmd(apsp_pkg::OP_READ, 15, 15, 0);
        push_cmd(apsp_pkg::OP_READ, 0, 0, 0);
        push_cmd(apsp_pkg::OP_READ, 1, 0, 0);
        drain_and_settle();

        // Random phases, each with a different vertex_count. Writes that go
        // past the active range are kept and come into play once a later
        // setting covers them.
        for (int p = 0; p < 7; p++)
        begin
            write_register(ADDR_VERTEX_COUNT, apsp_pkg::APB_DATA_W'(phase_counts[p]));
            steady_traffic = (p == 2 || p == 5);
            queue_random_items(phase_items[p], active_vertices(phase_counts[p]));
            drain_and_settle();
        end

        if (pending_answers.size() != 0)
        begin
            $error("%0d read answers never arrived", pending_answers.size());
            mismatch_count++;
        end

        $display("Run covered %0d edge writes, %0d solves and %0d pair reads (%0d checked),",
                 writes_seen, solves_seen, reads_seen, results_checked);
        $display("plus %0d dropped commands, over %0d vertex_count settings.",
                 dropped_seen, settings_used + 1);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/apsp_pkg.sv
rtl/apsp_in_if.sv
rtl/apsp_out_if.sv
rtl/apsp_ram.sv
rtl/apsp_front.sv
rtl/apsp_engine.sv
rtl/all_pairs_shortest_path.sv
tb/tb.sv
